// ----- rtl/lfdc_pkg.sv -----
// ----------------------------------------------------------------------------
// lfdc_pkg
// Shared types and constants for the line follow drive controller.
// ----------------------------------------------------------------------------
package lfdc_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int DUTY_BITS_DEF  = 10;

  localparam int ACC_W = 11;  // pwm accumulator, always within +/- 1023
  localparam int ERR_W = 4;   // line error in half units
  localparam int TGT_W = 12;  // wheel target
  localparam int Q_W   = 8;   // serial multiplier operand, one bit per cycle
  localparam int CNT_W = 4;   // multiplier bit counter
  localparam int CFG_W = 10;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_STEER_GAIN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_STEER_DAMP  = 3'd1;
  localparam logic [IDX_W-1:0] REG_MOTOR_GAIN  = 3'd2;
  localparam logic [IDX_W-1:0] REG_BASE_SPEED  = 3'd3;
  localparam logic [IDX_W-1:0] REG_PIVOT_SPEED = 3'd4;
  localparam logic [IDX_W-1:0] REG_SLOW_DOWN   = 3'd5;
  localparam logic [IDX_W-1:0] REG_DUTY_LIMIT  = 3'd6;

  localparam logic [8:0] RST_STEER_GAIN  = 9'd14;
  localparam logic [8:0] RST_STEER_DAMP  = 9'd45;
  localparam logic [7:0] RST_MOTOR_GAIN  = 8'd32;
  localparam logic [7:0] RST_BASE_SPEED  = 8'd40;
  localparam logic [6:0] RST_PIVOT_SPEED = 7'd20;
  localparam logic [6:0] RST_SLOW_DOWN   = 7'd10;
  localparam logic [9:0] RST_DUTY_LIMIT  = 10'd999;

  localparam logic [1:0] MODE_STOP   = 2'd0;
  localparam logic [1:0] MODE_FOLLOW = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;

  localparam logic [1:0] DIR_OFF = 2'd0;
  localparam logic [1:0] DIR_FWD = 2'd1;
  localparam logic [1:0] DIR_REV = 2'd2;

  localparam logic [CNT_W-1:0] NBITS_ERR  = 4'd4;
  localparam logic [CNT_W-1:0] NBITS_DERR = 4'd6;
  localparam logic [CNT_W-1:0] NBITS_GAIN = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEER_P,
    ST_STEER_D,
    ST_TURN,
    ST_LEFT_GO,
    ST_LEFT_MUL,
    ST_LEFT_POST,
    ST_LEFT_CLAMP,
    ST_RIGHT_GO,
    ST_RIGHT_MUL,
    ST_RIGHT_POST,
    ST_RIGHT_CLAMP,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic             start;
    logic             clear;
    logic             sgn;
    logic [CNT_W-1:0] nbits;
  } mul_ctl_t;

endpackage

// ----- rtl/line_follow_drive_controller_top.sv -----
// ----------------------------------------------------------------------------
// line_follow_drive_controller_top
// Follow mode: a request runs the bit-serial steering multiplies (4 + 6 bits),
// then per wheel a gain multiply (8 bits, one bit a cycle), post and clamp,
// then the result register loads; in_stall holds until that write is done.
// Manual and undefined mode skip the steering terms; stop goes to ST_WRITE.
// A finished result waiting on out_stall delays only the following request.
// Synchronous reset loads the register defaults and clears error and pwm state.
// ----------------------------------------------------------------------------
module line_follow_drive_controller_top import lfdc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int DUTY_BITS  = DUTY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [IDX_W-1:0]             cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [4:0]                   sensor_bits,
  input  logic signed [COUNT_BITS-1:0] count_left,
  input  logic signed [COUNT_BITS-1:0] count_right,
  input  logic [1:0]                   drive_mode,
  input  logic signed [10:0]           manual_left,
  input  logic signed [10:0]           manual_right,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [TGT_W-1:0]      target_left,
  output logic signed [TGT_W-1:0]      target_right,
  output logic [DUTY_BITS-1:0]         duty_left,
  output logic [DUTY_BITS-1:0]         duty_right,
  output logic [1:0]                   dir_left,
  output logic [1:0]                   dir_right,
  output logic signed [ERR_W-1:0]      line_error
);

  localparam int MW = ((COUNT_BITS > TGT_W) ? COUNT_BITS : TGT_W) + 1;
  localparam int PW = MW + Q_W;
  localparam logic [16:0] DMAX = 17'((1 << DUTY_BITS) - 1);
  localparam logic [4:0] SENS_NONE = 5'b00000;

  function automatic logic signed [ERR_W-1:0] map_sensors(
    input logic [4:0]              bits,
    input logic signed [ERR_W-1:0] prev
  );
    logic signed [ERR_W-1:0] e;
    unique case (bits) inside
      5'd4, 5'd14, 5'd31: e = 4'sd0;
      5'd12:              e = -4'sd1;
      5'd8:               e = -4'sd2;
      5'd24, 5'd20, 5'd28: e = -4'sd3;
      5'd16:              e = -4'sd4;
      5'd6:               e = 4'sd1;
      5'd2:               e = 4'sd2;
      5'd3, 5'd5, 5'd7:   e = 4'sd3;
      5'd1:               e = 4'sd4;
      SENS_NONE: begin
        // line lost: hold hard toward the side it was last seen on
        if (prev > 4'sd0) e = 4'sd4;
        else if (prev < 4'sd0) e = -4'sd4;
        else e = 4'sd0;
      end
      default:            e = prev;
    endcase
    return e;
  endfunction

  state_t state, state_next;

  // configuration
  logic signed [8:0] steer_gain;
  logic signed [8:0] steer_damp;
  logic [7:0]        motor_gain;
  logic signed [7:0] base_speed;
  logic [6:0]        pivot_mag;
  logic [6:0]        slow_down;
  logic [9:0]        duty_limit;

  // persistent state
  logic signed [ERR_W-1:0] prev_error;
  logic signed [ACC_W-1:0] acc_l, acc_r;

  // per-request registers
  logic [1:0]                   mode_q;
  logic signed [ERR_W-1:0]      err_q;
  logic signed [5:0]            derr2_q;
  logic signed [COUNT_BITS-1:0] act_l, act_r;
  logic signed [TGT_W-1:0]      tl, tr;
  logic signed [PW-1:0]         sum_q;

  logic                         accept, out_free;
  logic signed [ERR_W-1:0]      err_in;
  logic signed [4:0]            err_diff;
  logic signed [5:0]            derr2_in;
  logic                         cr_min;
  logic signed [COUNT_BITS-1:0] ar_in;

  mul_ctl_t             mul_ctl;
  logic signed [MW-1:0] mul_mcand;
  logic [Q_W-1:0]       mul_mplier;
  logic signed [PW-1:0] prod;
  logic                 mul_done;

  logic signed [MW-1:0]    diff_l, diff_r;
  logic signed [PW-1:0]    turn_adj, turn_full;
  logic signed [TGT_W-1:0] turn, base_adj, piv, turn_l, turn_r;
  logic [ERR_W-1:0]        abs_err;
  logic signed [PW-1:0]    quot_adj, quot, post_sum;
  logic signed [ACC_W-1:0] acc_sel, clamp_val;
  logic [9:0]              lim;
  logic signed [PW-1:0]    lim_pos, lim_neg;
  logic [9:0]              mag_l, mag_r;

  assign accept   = in_valid && (state == ST_IDLE);
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign err_in   = map_sensors(sensor_bits, prev_error);
  assign err_diff = 5'(err_in) - 5'(prev_error);
  assign derr2_in = {err_diff, 1'b0};

  // negated right count, most negative value saturates
  assign cr_min = (count_right == {1'b1, {(COUNT_BITS-1){1'b0}}});
  assign ar_in  = cr_min ? {1'b0, {(COUNT_BITS-1){1'b1}}} : -count_right;

  assign diff_l = MW'(tl) - MW'(act_l);
  assign diff_r = MW'(tr) - MW'(act_r);

  // steering term, divided by four toward zero
  assign turn_adj  = prod + (prod[PW-1] ? PW'(3) : PW'(0));
  assign turn_full = turn_adj >>> 2;
  assign turn      = turn_full[TGT_W-1:0];
  assign abs_err   = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
  assign base_adj  = TGT_W'(base_speed)
                   - ((abs_err == 4'd2) ? TGT_W'(slow_down) : TGT_W'(0));
  assign piv       = err_q[ERR_W-1] ? -TGT_W'(pivot_mag) : TGT_W'(pivot_mag);
  assign turn_l    = (abs_err >= 4'd3) ? piv : base_adj + turn;
  assign turn_r    = (abs_err >= 4'd3) ? -piv : base_adj - turn;

  // speed loop increment, divided by sixteen toward zero
  assign quot_adj = prod + (prod[PW-1] ? PW'(15) : PW'(0));
  assign quot     = quot_adj >>> 4;
  assign acc_sel  = (state == ST_LEFT_POST) ? acc_l : acc_r;
  assign post_sum = PW'(acc_sel) + quot;

  assign lim       = ({7'd0, duty_limit} > DMAX) ? DMAX[9:0] : duty_limit;
  assign lim_pos   = PW'({1'b0, lim});
  assign lim_neg   = -lim_pos;
  assign clamp_val = (sum_q > lim_pos) ? ACC_W'({1'b0, lim})
                   : (sum_q < lim_neg) ? -ACC_W'({1'b0, lim})
                   : sum_q[ACC_W-1:0];

  assign mag_l = 10'(acc_l[ACC_W-1] ? -acc_l : acc_l);
  assign mag_r = 10'(acc_r[ACC_W-1] ? -acc_r : acc_r);

  lfdc_mul #(.MW(MW), .PW(PW)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mul_ctl),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .prod   (prod),
    .done   (mul_done)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (drive_mode)
            MODE_STOP:   state_next = ST_WRITE;
            MODE_FOLLOW: state_next = ST_STEER_P;
            default:     state_next = ST_LEFT_GO;
          endcase
        end
      end
      ST_STEER_P:     if (mul_done) state_next = ST_STEER_D;
      ST_STEER_D:     if (mul_done) state_next = ST_TURN;
      ST_TURN:        state_next = ST_LEFT_GO;
      ST_LEFT_GO:     state_next = ST_LEFT_MUL;
      ST_LEFT_MUL:    if (mul_done) state_next = ST_LEFT_POST;
      ST_LEFT_POST:   state_next = ST_LEFT_CLAMP;
      ST_LEFT_CLAMP:  state_next = ST_RIGHT_GO;
      ST_RIGHT_GO:    state_next = ST_RIGHT_MUL;
      ST_RIGHT_MUL:   if (mul_done) state_next = ST_RIGHT_POST;
      ST_RIGHT_POST:  state_next = ST_RIGHT_CLAMP;
      ST_RIGHT_CLAMP: state_next = ST_WRITE;
      ST_WRITE:       if (out_free) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // multiplier requests
  always_comb begin
    mul_ctl    = '0;
    mul_mcand  = '0;
    mul_mplier = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && (drive_mode == MODE_FOLLOW)) begin
          mul_ctl    = '{start: 1'b1, clear: 1'b1, sgn: 1'b1, nbits: NBITS_ERR};
          mul_mcand  = MW'(steer_gain);
          mul_mplier = Q_W'(err_in);
        end
      end
      ST_STEER_P: begin
        if (mul_done) begin
          // derivative term adds onto the proportional product
          mul_ctl    = '{start: 1'b1, clear: 1'b0, sgn: 1'b1, nbits: NBITS_DERR};
          mul_mcand  = MW'(steer_damp);
          mul_mplier = Q_W'(derr2_q);
        end
      end
      ST_LEFT_GO: begin
        mul_ctl    = '{start: 1'b1, clear: 1'b1, sgn: 1'b0, nbits: NBITS_GAIN};
        mul_mcand  = diff_l;
        mul_mplier = motor_gain;
      end
      ST_RIGHT_GO: begin
        mul_ctl    = '{start: 1'b1, clear: 1'b1, sgn: 1'b0, nbits: NBITS_GAIN};
        mul_mcand  = diff_r;
        mul_mplier = motor_gain;
      end
      default: begin
        mul_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      steer_gain  <= RST_STEER_GAIN;
      steer_damp  <= RST_STEER_DAMP;
      motor_gain  <= RST_MOTOR_GAIN;
      base_speed  <= RST_BASE_SPEED;
      pivot_mag   <= RST_PIVOT_SPEED;
      slow_down   <= RST_SLOW_DOWN;
      duty_limit  <= RST_DUTY_LIMIT;
      prev_error  <= '0;
      acc_l       <= '0;
      acc_r       <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_STEER_GAIN:  steer_gain  <= cfg_data[8:0];
          REG_STEER_DAMP:  steer_damp  <= cfg_data[8:0];
          REG_MOTOR_GAIN:  motor_gain  <= cfg_data[7:0];
          REG_BASE_SPEED:  base_speed  <= cfg_data[7:0];
          REG_PIVOT_SPEED: pivot_mag   <= cfg_data[6:0];
          REG_SLOW_DOWN:   slow_down   <= cfg_data[6:0];
          REG_DUTY_LIMIT:  duty_limit  <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (drive_mode == MODE_STOP) begin
          prev_error <= '0;
          acc_l      <= '0;
          acc_r      <= '0;
        end else if (drive_mode == MODE_FOLLOW) begin
          prev_error <= err_in;
        end
      end
      if (state == ST_LEFT_CLAMP) acc_l <= clamp_val;
      if (state == ST_RIGHT_CLAMP) acc_r <= clamp_val;
      if ((state == ST_WRITE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= drive_mode;
      err_q   <= err_in;
      derr2_q <= derr2_in;
      act_l   <= count_left;
      act_r   <= ar_in;
      if (drive_mode == MODE_MANUAL) begin
        tl <= TGT_W'(manual_left);
        tr <= TGT_W'(manual_right);
      end else begin
        tl <= '0;
        tr <= '0;
      end
    end
    if (state == ST_TURN) begin
      tl <= turn_l;
      tr <= turn_r;
    end
    if ((state == ST_LEFT_POST) || (state == ST_RIGHT_POST)) begin
      sum_q <= post_sum;
    end
    if ((state == ST_WRITE) && out_free) begin
      target_left  <= tl;
      target_right <= tr;
      duty_left    <= DUTY_BITS'(mag_l);
      duty_right   <= DUTY_BITS'(mag_r);
      line_error   <= prev_error;
      if (mode_q == MODE_STOP) begin
        dir_left  <= DIR_OFF;
        dir_right <= DIR_OFF;
      end else begin
        dir_left  <= acc_l[ACC_W-1] ? DIR_REV : DIR_FWD;
        dir_right <= acc_r[ACC_W-1] ? DIR_REV : DIR_FWD;
      end
    end
  end

endmodule

// ----- rtl/lfdc_mul.sv -----
// ----------------------------------------------------------------------------
// lfdc_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, with an
// accumulating product register shared by steering and both speed loops.
// ----------------------------------------------------------------------------
module lfdc_mul import lfdc_pkg::*; #(
  parameter int MW = 17,
  parameter int PW = MW + Q_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mul_ctl_t             ctl,
  input  logic signed [MW-1:0] mcand,
  input  logic [Q_W-1:0]       mplier,
  output logic signed [PW-1:0] prod,
  output logic                 done
);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic signed [PW-1:0] mreg;
  logic [Q_W-1:0]       qreg;
  logic                 sgn;
  logic                 last;

  assign last = busy && (cnt == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= last;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.nbits;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mreg <= PW'(mcand);
      qreg <= mplier;
      sgn  <= ctl.sgn;
      if (ctl.clear) begin
        prod <= '0;
      end
    end else if (busy) begin
      // two's complement operand: the top bit carries negative weight
      if (qreg[0]) begin
        if (sgn && last) begin
          prod <= prod - mreg;
        end else begin
          prod <= prod + mreg;
        end
      end
      mreg <= mreg <<< 1;
      qreg <= qreg >> 1;
    end
  end

endmodule

// ----- rtl/lfdc_checker.sv -----
// ----------------------------------------------------------------------------
// lfdc_checker
// Port-level checks on the drive controller, bound to the top level.
// ----------------------------------------------------------------------------
module lfdc_checker import lfdc_pkg::*; #(
  parameter int DUTY_BITS = DUTY_BITS_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [1:0]              drive_mode,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [TGT_W-1:0] target_left,
  input logic [DUTY_BITS-1:0]    duty_left,
  input logic [DUTY_BITS-1:0]    duty_right,
  input logic [1:0]              dir_left,
  input logic [1:0]              dir_right,
  input logic signed [ERR_W-1:0] line_error
);

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous request in flight");

  // stop request with a free result register shows all-off once past ST_WRITE
  a_stop_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (drive_mode == MODE_STOP) && !out_valid
    |=> ##1 (out_valid && (dir_left == DIR_OFF) && (dir_right == DIR_OFF)
             && (duty_left == '0) && (duty_right == '0) && (line_error == '0)
             && (target_left == '0)))
    else $error("stop request result wrong");

  // a bridge is only off together with zero duty and the other bridge off
  a_dir_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((dir_left == DIR_OFF) || (dir_right == DIR_OFF))
    |-> (dir_left == DIR_OFF) && (dir_right == DIR_OFF)
        && (duty_left == '0) && (duty_right == '0))
    else $error("bridge off with nonzero duty or mismatched direction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(duty_left) && $stable(dir_left))
    else $error("stalled result changed");

endmodule

bind line_follow_drive_controller_top lfdc_checker #(.DUTY_BITS(DUTY_BITS)) u_checker (.*);
